[rtl/ccl_pkg.sv]
`timescale 1ns / 1ps

package ccl_pkg;

    localparam logic [7:0] FRAME_HEADER = 8'hCC;
    localparam logic [7:0] CID_INFO     = 8'h00;
    localparam logic [7:0] CID_COMMAND  = 8'h01;
    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [2:0] REPLY_LEN    = 3'd5;
    localparam int         MAX_RESULTS  = 4;

    typedef enum logic [1:0] {
        OP_INFO  = 2'd0,
        OP_CMD   = 2'd1,
        OP_RX    = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEED = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_TX    = 1'b0,
        KIND_CHECK = 1'b1
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic [7:0] action_code;
        logic [7:0] rx_byte;
        logic [3:0] feature_index;
    } t_item;

    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] tx_byte;
        logic       frame_last;
        t_status    status;
        logic       feature_present;
    } t_result;

    typedef struct packed {
        logic [2:0]                      count;
        t_result [MAX_RESULTS-1:0]       entries;
    } t_frame;

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    function automatic t_result tx_entry(input logic [7:0] b, input logic last);
        t_result r;
        r.result_kind     = KIND_TX;
        r.tx_byte         = b;
        r.frame_last      = last;
        r.status          = ST_OK;
        r.feature_present = 1'b0;
        return r;
    endfunction

endpackage

[rtl/ccl_if.sv]
`timescale 1ns / 1ps

interface ccl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] action_code;
    logic [7:0] rx_byte;
    logic [3:0] feature_index;

    modport source (output valid, output operation, output action_code, output rx_byte,
                    output feature_index, input ready);
    modport sink   (input valid, input operation, input action_code, input rx_byte,
                    input feature_index, output ready);
endinterface

interface ccl_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [1:0] status;
    logic       feature_present;

    modport source (output valid, output result_kind, output tx_byte, output frame_last,
                    output status, output feature_present, input ready);
    modport sink   (input valid, input result_kind, input tx_byte, input frame_last,
                    input status, input feature_present, output ready);
endinterface

[rtl/ccl_rx.sv]
`timescale 1ns / 1ps

module ccl_rx (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ccl_pkg::t_item   i_item,
    output ccl_pkg::t_result o_answer
);

    logic [2:0]  r_remaining, n_remaining;
    logic [2:0]  r_received, n_received;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_header;
    logic [15:0] r_features;
    logic [7:0]  r_crc_byte;
    logic        armed;

    assign armed = (r_remaining != 3'd0);

    always_comb begin
        n_remaining = r_remaining;
        n_received  = r_received;
        n_crc       = r_crc;
        if (i_accept && i_item.op == ccl_pkg::OP_INFO) begin
            n_remaining = ccl_pkg::REPLY_LEN;
            n_received  = 3'd0;
            n_crc       = 8'h00;
        end else if (i_accept && i_item.op == ccl_pkg::OP_RX && armed) begin
            n_remaining = r_remaining - 3'd1;
            n_received  = r_received + 3'd1;
            if (r_received < 3'd4) begin
                n_crc = ccl_pkg::crc_step(r_crc, i_item.rx_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 3'd0;
            r_received  <= 3'd0;
            r_crc       <= 8'h00;
        end else begin
            r_remaining <= n_remaining;
            r_received  <= n_received;
            r_crc       <= n_crc;
        end
    end

    // reply bytes, stored in arrival order
    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.op == ccl_pkg::OP_RX && armed) begin
            unique case (r_received)
                3'd0:    r_header         <= i_item.rx_byte;
                3'd2:    r_features[7:0]  <= i_item.rx_byte;
                3'd3:    r_features[15:8] <= i_item.rx_byte;
                3'd4:    r_crc_byte       <= i_item.rx_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_answer.result_kind     = ccl_pkg::KIND_CHECK;
        o_answer.tx_byte         = 8'h00;
        o_answer.frame_last      = 1'b1;
        o_answer.feature_present = 1'b0;
        priority if (armed) begin
            o_answer.status = ccl_pkg::ST_NEED;
        end else if (r_received != ccl_pkg::REPLY_LEN || r_crc != r_crc_byte
                     || r_header != ccl_pkg::FRAME_HEADER) begin
            o_answer.status = ccl_pkg::ST_BAD;
        end else begin
            o_answer.status          = ccl_pkg::ST_OK;
            o_answer.feature_present = r_features[i_item.feature_index];
        end
    end

endmodule

[rtl/ccl_emit.sv]
`timescale 1ns / 1ps

module ccl_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ccl_pkg::t_frame i_frame,
    output logic           o_can_load,
    ccl_out_if.source      o_res
);

    localparam int IdxW = $clog2(ccl_pkg::MAX_RESULTS);

    ccl_pkg::t_result [ccl_pkg::MAX_RESULTS-1:0] r_entries;
    logic [2:0]      r_count;
    logic [IdxW-1:0] r_idx;
    logic            take;
    logic            at_last;
    ccl_pkg::t_result cur;

    assign take       = o_res.valid && o_res.ready;
    assign at_last    = ({1'b0, r_idx} == r_count - 3'd1);
    assign o_can_load = (r_count == 3'd0) || (take && at_last);
    assign cur        = r_entries[r_idx];

    assign o_res.valid           = (r_count != 3'd0);
    assign o_res.result_kind     = cur.result_kind;
    assign o_res.tx_byte         = cur.tx_byte;
    assign o_res.frame_last      = cur.frame_last;
    assign o_res.status          = cur.status;
    assign o_res.feature_present = cur.feature_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_count <= i_frame.count;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_count <= 3'd0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entries <= i_frame.entries;
        end
    end

endmodule

[rtl/camera_control_link_framer.sv]
`timescale 1ns / 1ps

// channel  | dir | payload
// i_req    | in  | operation, action_code, rx_byte, feature_index
// o_res    | out | result_kind, tx_byte, frame_last, status, feature_present
//
// each item's results leave a result buffer one per cycle while o_res is ready
// info request: 3 bytes, command: 4 bytes, check: 1 answer, received byte: none
// a new request is taken when the buffer is empty or its last result is being taken
// the result buffer depth (four entries) bounds the results of each item
// reset is synchronous, active low; it disarms the receiver and empties the buffer
// stalls on o_res hold the current result and block i_req

module camera_control_link_framer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccl_in_if.sink    i_req,
    ccl_out_if.source o_res
);

    localparam logic [7:0] InfoCrc =
        ccl_pkg::crc_step(ccl_pkg::crc_step(8'h00, ccl_pkg::FRAME_HEADER), ccl_pkg::CID_INFO);
    localparam logic [7:0] CmdCrc =
        ccl_pkg::crc_step(ccl_pkg::crc_step(8'h00, ccl_pkg::FRAME_HEADER),
                          ccl_pkg::CID_COMMAND);

    ccl_pkg::t_item   item;
    ccl_pkg::t_result answer;
    ccl_pkg::t_frame  frame;
    logic             can_load;
    logic             accept;

    assign item.op            = ccl_pkg::t_op'(i_req.operation);
    assign item.action_code   = i_req.action_code;
    assign item.rx_byte       = i_req.rx_byte;
    assign item.feature_index = i_req.feature_index;

    assign i_req.ready = can_load;
    assign accept      = i_req.valid && can_load;

    ccl_rx u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_answer (answer)
    );

    always_comb begin
        frame.entries = '0;
        unique case (item.op)
            ccl_pkg::OP_INFO: begin
                frame.count      = 3'd3;
                frame.entries[0] = ccl_pkg::tx_entry(ccl_pkg::FRAME_HEADER, 1'b0);
                frame.entries[1] = ccl_pkg::tx_entry(ccl_pkg::CID_INFO, 1'b0);
                frame.entries[2] = ccl_pkg::tx_entry(InfoCrc, 1'b1);
            end
            ccl_pkg::OP_CMD: begin
                frame.count      = 3'd4;
                frame.entries[0] = ccl_pkg::tx_entry(ccl_pkg::FRAME_HEADER, 1'b0);
                frame.entries[1] = ccl_pkg::tx_entry(ccl_pkg::CID_COMMAND, 1'b0);
                frame.entries[2] = ccl_pkg::tx_entry(item.action_code, 1'b0);
                frame.entries[3] = ccl_pkg::tx_entry(
                    ccl_pkg::crc_step(CmdCrc, item.action_code), 1'b1);
            end
            ccl_pkg::OP_RX: begin
                frame.count = 3'd0;
            end
            ccl_pkg::OP_CHECK: begin
                frame.count      = 3'd1;
                frame.entries[0] = answer;
            end
            default: begin
                frame.count = 3'd0;
            end
        endcase
    end

    ccl_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_frame    (frame),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    a_check_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result_kind |-> o_res.frame_last)
        else $error("check answer without frame_last");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_req.ready)
        else $error("request taken while result stalled");

    a_rx_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.operation == ccl_pkg::OP_RX
        && !o_res.valid |=> !o_res.valid)
        else $error("received byte produced a result");

endmodule
